// File: src/pcm_unpack_deinterleave_unit_assert.svh
// Assertion macros for the PCM unpack block
`ifndef PCM_UNPACK_DEINTERLEAVE_UNIT_ASSERT_SVH
`define PCM_UNPACK_DEINTERLEAVE_UNIT_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define PUD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define PUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pud_pkg.sv
// ---------------------------------------------------------------------------
// pud_pkg
// Shared constants, types, the per-format last-byte helper and the float64 to float32 conversion.
// ---------------------------------------------------------------------------
package pud_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int FRAME_BITS   = 24;
    localparam int CHAN_BITS    = $clog2(MAX_CHANNELS);
    localparam int IDX_BITS     = 28;

    localparam logic [2:0] FMT_INT8  = 3'd0;
    localparam logic [2:0] FMT_INT16 = 3'd1;
    localparam logic [2:0] FMT_INT24 = 3'd2;
    localparam logic [2:0] FMT_INT32 = 3'd3;
    localparam logic [2:0] FMT_F32   = 3'd4;
    localparam logic [2:0] FMT_F64   = 3'd5;

    localparam logic [1:0] REG_FORMAT   = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_FRAMES   = 2'd2;

    typedef struct packed {
        logic [2:0]            sample_format;
        logic [CHAN_BITS-1:0]  chan_last;
        logic [FRAME_BITS-1:0] frames;
        logic                  restart;
    } cfg_t;

    function automatic logic [2:0] last_byte(input logic [2:0] fmt);
        case (fmt)
            FMT_INT16: last_byte = 3'd1;
            FMT_INT24: last_byte = 3'd2;
            FMT_INT32: last_byte = 3'd3;
            FMT_F32:   last_byte = 3'd3;
            FMT_F64:   last_byte = 3'd7;
            default:   last_byte = 3'd0;
        endcase
    endfunction

    function automatic logic [31:0] f64_to_f32(input logic [63:0] b);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] man;
        logic [12:0] e;
        logic [63:0] full;
        logic [5:0]  sh;
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] res;
        sgn  = b[63];
        ex   = b[62:52];
        man  = b[51:0];
        e    = {2'b00, ex} - 13'd896;
        full = {11'd0, 1'b1, man};
        sh   = 6'd0;
        r    = '0;
        rem  = '0;
        half = '0;
        if (ex == 11'h7FF) begin
            if (man == '0) res = 32'h7F800000;
            else res = 32'h7FC00000 | {9'd0, man[51:29]};
        end else if (ex == 11'd0) begin
            res = 32'd0;
        end else if (!e[12] && e >= 13'd255) begin
            res = 32'h7F800000;
        end else if (!e[12] && e != 13'd0) begin
            r    = {41'd0, man[51:29]};
            rem  = {35'd0, man[28:0]};
            half = 64'd1 << 28;
            if (rem > half || (rem == half && r[0])) r = r + 64'd1;
            res = {1'b0, e[7:0], 23'd0} + r[31:0];
        end else if (e[12] && e < 13'h1FE2) begin
            res = 32'd0;
        end else begin
            // shift reaches 60, so the rounding terms need the full 64 bits
            sh   = 6'(13'd30 - e);
            r    = full >> sh;
            rem  = full & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 6'd1);
            if (rem > half || (rem == half && r[0])) r = r + 64'd1;
            res = r[31:0];
        end
        f64_to_f32 = {sgn | res[31], res[30:0]};
    endfunction

endpackage

// File: src/pud_cfg_regs.sv
// ---------------------------------------------------------------------------
// pud_cfg_regs
// APB register file for format, channel count and frame count.
// ---------------------------------------------------------------------------
module pud_cfg_regs
    import pud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    logic [2:0]            format_reg;
    logic [4:0]            chans_reg;
    logic [FRAME_BITS-1:0] frames_reg;
    logic                  wr;
    logic [1:0]            idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            format_reg <= FMT_INT16;
            chans_reg  <= 5'd2;
            frames_reg <= FRAME_BITS'(1);
        end else if (wr) begin
            case (idx)
                REG_FORMAT:   format_reg <= pwdata[2:0];
                REG_CHANNELS: chans_reg  <= pwdata[4:0];
                REG_FRAMES:   frames_reg <= pwdata[FRAME_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FORMAT:   prdata = {29'd0, format_reg};
            REG_CHANNELS: prdata = {27'd0, chans_reg};
            REG_FRAMES:   prdata = {{(32-FRAME_BITS){1'b0}}, frames_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.sample_format = format_reg;
    assign cfg.chan_last = (chans_reg == 5'd0) ? '0 :
                           (chans_reg > 5'(MAX_CHANNELS)) ? CHAN_BITS'(MAX_CHANNELS - 1) :
                           CHAN_BITS'(chans_reg - 5'd1);
    assign cfg.frames  = (frames_reg == '0) ? FRAME_BITS'(1) : frames_reg;
    assign cfg.restart = wr && (idx == REG_FORMAT || idx == REG_CHANNELS ||
                                idx == REG_FRAMES);
endmodule

// File: src/pcm_unpack_deinterleave_unit.sv
// A completed sample appears at the output register in the cycle after its last byte.
// One byte per clock while in_ready is high; the single output register is the only stage.
// A full output register that is being taken still accepts a byte in the same cycle.
// Reset (rst_n, async low): stream counters cleared, format int16, two channels, one frame.
// ---------------------------------------------------------------------------
// pcm_unpack_deinterleave_unit
// Byte-stream sample assembly, format conversion and planar indexing.
// ---------------------------------------------------------------------------
module pcm_unpack_deinterleave_unit
    import pud_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         sample_word,
    output logic [IDX_BITS-1:0] dest_index
);
    `include "pcm_unpack_deinterleave_unit_assert.svh"

    cfg_t cfg;

    logic [55:0]           shift_reg;
    logic [2:0]            pos_reg;
    logic [CHAN_BITS-1:0]  chan_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [CHAN_BITS-1:0]  chan_next;
    logic [FRAME_BITS-1:0] frame_next;
    logic                  out_valid_reg;
    logic [31:0]           word_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [63:0]           full_word;
    logic [31:0]           word_next;
    logic [IDX_BITS-1:0]   idx_next;
    logic                  accept;
    logic                  done;

    pud_cfg_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign done     = (pos_reg == last_byte(cfg.sample_format));

    always_comb begin
        full_word = {8'd0, shift_reg};
        full_word[pos_reg*8 +: 8] = data_byte;
        case (cfg.sample_format)
            FMT_INT16: word_next = {full_word[15:0], 16'd0};
            FMT_INT24: word_next = {full_word[23:0], 8'd0};
            FMT_INT32: word_next = full_word[31:0];
            FMT_F32:   word_next = full_word[31:0];
            FMT_F64:   word_next = f64_to_f32(full_word);
            default:   word_next = {full_word[7:0], 24'd0};
        endcase
        idx_next = IDX_BITS'(chan_reg * cfg.frames) + IDX_BITS'(frame_reg);
        chan_next  = chan_reg;
        frame_next = frame_reg;
        if (chan_reg >= cfg.chan_last) begin
            chan_next = '0;
            if (frame_reg + FRAME_BITS'(1) >= cfg.frames || frame_reg == '1)
                frame_next = '0;
            else
                frame_next = frame_reg + FRAME_BITS'(1);
        end else begin
            chan_next = chan_reg + CHAN_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg   <= '0;
            chan_reg  <= '0;
            frame_reg <= '0;
            shift_reg <= '0;
        end else if (cfg.restart) begin
            pos_reg   <= '0;
            chan_reg  <= '0;
            frame_reg <= '0;
            shift_reg <= '0;
        end else if (accept) begin
            if (done) begin
                pos_reg   <= '0;
                shift_reg <= '0;
                chan_reg  <= chan_next;
                frame_reg <= frame_next;
            end else begin
                pos_reg   <= pos_reg + 3'd1;
                shift_reg <= full_word[55:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (accept && done) out_valid_reg <= 1'b1;
        else if (out_ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (accept && done) begin
            word_reg <= word_next;
            idx_reg  <= idx_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_word = word_reg;
    assign dest_index  = idx_reg;

    `PUD_ASSERT_NEXT(a_done_valid, accept && done && !cfg.restart, out_valid,
        "completed sample not presented")
    `PUD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(sample_word),
        "stalled word changed")
    `PUD_ASSERT(a_chan_range, chan_reg <= cfg.chan_last || cfg.restart || $past(cfg.restart),
        "channel counter out of range")
endmodule
